/* design/rdq_pkg.sv */
`timescale 1ns / 1ps

package rdq_pkg;

  // Fixed field widths
  localparam int YEAR_W  = 12;
  localparam int TITLE_W = 16;
  localparam int CNT_W   = 7;

  // Request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_DELETE     = 3'd4;
  localparam logic [2:0] REQ_COUNT      = 3'd5;

  // Predicate codes
  localparam logic [1:0] MATCH_FLAG_SET   = 2'd0;
  localparam logic [1:0] MATCH_FLAG_CLR   = 2'd1;
  localparam logic [1:0] MATCH_YEAR_ABOVE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // One stored record
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic               flag;
    logic [TITLE_W-1:0] title;
  } rec_t;

  // Input word
  typedef struct packed {
    logic [2:0]         req_type;
    logic [YEAR_W-1:0]  entry_year;
    logic               entry_flag;
    logic [TITLE_W-1:0] entry_title_ref;
    logic [1:0]         match_kind;
    logic [YEAR_W-1:0]  year_limit;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic               out_flag;
    logic [TITLE_W-1:0] out_title_ref;
    logic [CNT_W-1:0]   match_count;
    logic [CNT_W-1:0]   list_size;
    logic [1:0]         status;
  } out_word_t;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_POP  = 6'b000100,
    S_RD   = 6'b001000,
    S_EV   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // Evaluate the predicate on one record
  function automatic logic rec_match(input rec_t rec, input logic [1:0] kind,
                                     input logic [YEAR_W-1:0] limit);
    logic hit;
    hit = 1'b0;
    case (kind)
      MATCH_FLAG_SET:   hit = rec.flag;
      MATCH_FLAG_CLR:   hit = ~rec.flag;
      MATCH_YEAR_ABOVE: hit = (rec.year > limit);
      default:          hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

/* design/record_deque_with_filter.sv */
`timescale 1ns / 1ps

// Channel   Ports                         Dir  Word
// input     in_valid  in_ready  in_data   in   rdq_pkg::in_word_t
// result    out_valid out_ready out_data  out  rdq_pkg::out_word_t
//
// Push and no-op requests pass through S_EXEC and S_DONE to the result register;
// pops that find a record add S_POP. Delete and count walk the stored records
// through the single read port, one S_RD and one S_EV state per record.
// Reset clears the head pointer, the record count and the result valid; the
// record memory is not cleared. A stalled result holds in the output register;
// the next word may be accepted meanwhile and waits at its end for that slot.

module record_deque_with_filter #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rdq_pkg::in_word_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rdq_pkg::out_word_t    out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  rdq_pkg::state_t    state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      wpos_r, wpos_nxt;
  logic [CW-1:0]      mcnt_r, mcnt_nxt;
  rdq_pkg::in_word_t  req_r, req_nxt;
  rdq_pkg::out_word_t res_r, res_nxt;
  rdq_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [CW-1:0]      slot_pos;
  logic [SW-1:0]      slot_sum;
  logic [SW-1:0]      slot_wrap;
  logic [IW-1:0]      slot_addr;
  logic [IW-1:0]      head_dec;
  logic [IW-1:0]      head_inc;
  logic               full;
  logic               empty;
  logic               is_push;
  logic               is_pop;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  rdq_pkg::rec_t      wr_data;
  logic [IW-1:0]      rd_addr;
  rdq_pkg::rec_t      rd_data;
  logic               hit;

  rdq_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == rdq_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign is_push = (req_r.req_type == rdq_pkg::REQ_PUSH_FRONT) ||
                   (req_r.req_type == rdq_pkg::REQ_PUSH_BACK);
  assign is_pop  = (req_r.req_type == rdq_pkg::REQ_POP_FRONT) ||
                   (req_r.req_type == rdq_pkg::REQ_POP_BACK);

  // Pick the logical position for the shared slot adder
  always_comb begin
    slot_pos = count_r;
    case (state_r)
      rdq_pkg::S_RD: slot_pos = pos_r;
      rdq_pkg::S_EV: slot_pos = wpos_r;
      default: begin
        if (req_r.req_type == rdq_pkg::REQ_POP_BACK) begin
          slot_pos = count_r - 1'b1;
        end
      end
    endcase
  end

  // Map position to slot around the ring
  assign slot_sum  = SW'(head_r) + SW'(slot_pos);
  assign slot_wrap = (slot_sum >= SW'(CAPACITY)) ? (slot_sum - SW'(CAPACITY)) : slot_sum;
  assign slot_addr = slot_wrap[IW-1:0];

  assign head_dec = (head_r == '0) ? IW'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IW'(CAPACITY - 1)) ? '0 : head_r + 1'b1;

  assign hit = rdq_pkg::rec_match(rd_data, req_r.match_kind, req_r.year_limit);

  // Memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_addr;
    wr_data = rd_data;
    rd_addr = slot_addr;
    case (state_r)
      rdq_pkg::S_EXEC: begin
        wr_data.year  = req_r.entry_year;
        wr_data.flag  = req_r.entry_flag;
        wr_data.title = req_r.entry_title_ref;
        wr_en         = is_push && !full;
        if (req_r.req_type == rdq_pkg::REQ_PUSH_FRONT) begin
          wr_addr = head_dec;
        end
        if (req_r.req_type == rdq_pkg::REQ_POP_FRONT) begin
          rd_addr = head_r;
        end
      end
      rdq_pkg::S_EV: begin
        // Only a delete rewrites the store; a count leaves it as it is
        wr_en = !hit && (req_r.req_type == rdq_pkg::REQ_DELETE);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    wpos_nxt      = wpos_r;
    mcnt_nxt      = mcnt_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      rdq_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          mcnt_nxt  = '0;
          pos_nxt   = '0;
          wpos_nxt  = '0;
          state_nxt = rdq_pkg::S_EXEC;
        end
      end
      rdq_pkg::S_EXEC: begin
        state_nxt = rdq_pkg::S_DONE;
        if (is_push) begin
          if (full) begin
            res_nxt.status = rdq_pkg::STAT_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
            if (req_r.req_type == rdq_pkg::REQ_PUSH_FRONT) begin
              head_nxt = head_dec;
            end
          end
        end else if (is_pop) begin
          if (empty) begin
            res_nxt.status = rdq_pkg::STAT_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            if (req_r.req_type == rdq_pkg::REQ_POP_FRONT) begin
              head_nxt = head_inc;
            end
            state_nxt = rdq_pkg::S_POP;
          end
        end else if ((req_r.req_type == rdq_pkg::REQ_DELETE) ||
                     (req_r.req_type == rdq_pkg::REQ_COUNT)) begin
          state_nxt = rdq_pkg::S_RD;
        end
      end
      rdq_pkg::S_POP: begin
        // Capture the popped record
        res_nxt.out_year      = rd_data.year;
        res_nxt.out_flag      = rd_data.flag;
        res_nxt.out_title_ref = rd_data.title;
        state_nxt             = rdq_pkg::S_DONE;
      end
      rdq_pkg::S_RD: begin
        if (pos_r == count_r) begin
          if (req_r.req_type == rdq_pkg::REQ_DELETE) begin
            count_nxt = wpos_r;
          end
          state_nxt = rdq_pkg::S_DONE;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = rdq_pkg::S_EV;
        end
      end
      rdq_pkg::S_EV: begin
        // Count a hit, or compact the survivor toward the head
        if (hit) begin
          mcnt_nxt = mcnt_r + 1'b1;
        end else begin
          wpos_nxt = wpos_r + 1'b1;
        end
        state_nxt = rdq_pkg::S_RD;
      end
      rdq_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt             = res_r;
          out_nxt.match_count = rdq_pkg::CNT_W'(mcnt_r);
          out_nxt.list_size   = rdq_pkg::CNT_W'(count_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = rdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rdq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdq_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    wpos_r <= wpos_nxt;
    mcnt_r <= mcnt_nxt;
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count exceeds capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == rdq_pkg::S_EXEC))
    else $error("accepted word did not start execution");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rdq_pkg::S_RD) || (state_r == rdq_pkg::S_EV)) |-> (wpos_r <= pos_r))
    else $error("compaction write pointer passed read pointer");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rdq_pkg::S_DONE) && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("finished word not presented");

endmodule

/* design/rdq_store.sv */
`timescale 1ns / 1ps

module rdq_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  rdq_pkg::rec_t    wr_data,
  input  logic [AW-1:0]    rd_addr,
  output rdq_pkg::rec_t    rd_data
);

  rdq_pkg::rec_t mem [DEPTH];
  rdq_pkg::rec_t rd_data_r;

  // Write one record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* tb/record_deque_with_filter_tb.sv */
`timescale 1ns / 1ps

module record_deque_with_filter_tb;

  localparam int DEPTH       = 64;
  localparam int SEG_LEN     = 40;
  localparam int SEGMENTS    = 40;
  localparam int CALM_SEGS   = 4;
  localparam int HOLD_CYCLES = 250;
  localparam int TAIL_CYCLES = 2 * DEPTH + 20;
  localparam int MAX_PRINTS  = 40;

  // Codes the package leaves unnamed
  localparam logic [2:0] REQ_NOP_6    = 3'd6;
  localparam logic [2:0] REQ_NOP_7    = 3'd7;
  localparam logic [1:0] MATCH_UNUSED = 2'd3;

  // Years that matter to the original record list
  localparam int YEAR_OLD = 2010;
  localparam int YEAR_NEW = 2023;

  // Request mixes for the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  typedef struct {
    rdq_pkg::in_word_t  w;
    bit                 fixed;
    rdq_pkg::out_word_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rdq_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rdq_pkg::out_word_t out_data;

  rdq_pkg::rec_t      held_recs[$];
  rdq_pkg::out_word_t due_results[$];
  dir_row_t           typed_results[$];
  dir_row_t           dir_rows[$];
  int                 err_count = 0;
  bit                 tx_gaps;
  bit                 rx_gaps;
  bit                 rx_hold_req;

  record_deque_with_filter #(.CAPACITY(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Print a line per mismatch, up to MAX_PRINTS, and count every one
  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (err_count < MAX_PRINTS) begin
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
    err_count++;
  endtask

  // Predicate on one held record
  function automatic bit rec_hits(input rdq_pkg::rec_t r, input logic [1:0] kind,
                                  input logic [rdq_pkg::YEAR_W-1:0] limit);
    if (kind == rdq_pkg::MATCH_FLAG_SET) return r.flag == 1'b1;
    if (kind == rdq_pkg::MATCH_FLAG_CLR) return r.flag == 1'b0;
    if (kind == rdq_pkg::MATCH_YEAR_ABOVE) return r.year > limit;
    return 1'b0;
  endfunction

  // Advance the record list by one request and return its result word
  function automatic rdq_pkg::out_word_t apply_request(input rdq_pkg::in_word_t w);
    rdq_pkg::out_word_t res;
    rdq_pkg::rec_t      r;
    rdq_pkg::rec_t      kept[$];
    res = '0;
    case (w.req_type)
      rdq_pkg::REQ_PUSH_FRONT, rdq_pkg::REQ_PUSH_BACK: begin
        if (held_recs.size() >= DEPTH) begin
          res.status = rdq_pkg::STAT_FULL;
        end else begin
          r.year  = w.entry_year;
          r.flag  = w.entry_flag;
          r.title = w.entry_title_ref;
          if (w.req_type == rdq_pkg::REQ_PUSH_FRONT) held_recs.push_front(r);
          else held_recs.push_back(r);
        end
      end
      rdq_pkg::REQ_POP_FRONT, rdq_pkg::REQ_POP_BACK: begin
        if (held_recs.size() == 0) begin
          res.status = rdq_pkg::STAT_EMPTY;
        end else begin
          if (w.req_type == rdq_pkg::REQ_POP_FRONT) r = held_recs.pop_front();
          else r = held_recs.pop_back();
          res.out_year      = r.year;
          res.out_flag      = r.flag;
          res.out_title_ref = r.title;
        end
      end
      rdq_pkg::REQ_DELETE: begin
        foreach (held_recs[i]) begin
          if (rec_hits(held_recs[i], w.match_kind, w.year_limit))
            res.match_count = res.match_count + 1'b1;
          else
            kept.push_back(held_recs[i]);
        end
        held_recs = kept;
      end
      rdq_pkg::REQ_COUNT: begin
        foreach (held_recs[i]) begin
          if (rec_hits(held_recs[i], w.match_kind, w.year_limit))
            res.match_count = res.match_count + 1'b1;
        end
      end
      default: ;
    endcase
    res.list_size = rdq_pkg::CNT_W'(held_recs.size());
    return res;
  endfunction

  function automatic rdq_pkg::in_word_t req_word(input logic [2:0] req, input int year,
                                                 input int flag, input int title,
                                                 input logic [1:0] kind, input int limit);
    rdq_pkg::in_word_t w;
    w.req_type        = req;
    w.entry_year      = rdq_pkg::YEAR_W'(year);
    w.entry_flag      = 1'(flag);
    w.entry_title_ref = rdq_pkg::TITLE_W'(title);
    w.match_kind      = kind;
    w.year_limit      = rdq_pkg::YEAR_W'(limit);
    return w;
  endfunction

  function automatic rdq_pkg::out_word_t res_word(input int year, input int flag,
                                                  input int title, input int cnt,
                                                  input int size,
                                                  input logic [1:0] status);
    rdq_pkg::out_word_t o;
    o.out_year      = rdq_pkg::YEAR_W'(year);
    o.out_flag      = 1'(flag);
    o.out_title_ref = rdq_pkg::TITLE_W'(title);
    o.match_count   = rdq_pkg::CNT_W'(cnt);
    o.list_size     = rdq_pkg::CNT_W'(size);
    o.status        = status;
    return o;
  endfunction

  function automatic void add_row(input rdq_pkg::in_word_t w, input bit fixed,
                                  input rdq_pkg::out_word_t want);
    dir_row_t row;
    row.w     = w;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic int pick_year();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 4095;
      2:       return $urandom_range(YEAR_OLD - 5, YEAR_NEW + 5);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // Random request, weighted by the current mix
  function automatic rdq_pkg::in_word_t rand_request(input int mode);
    rdq_pkg::in_word_t w;
    int                r;
    logic [2:0]        push_req;
    logic [2:0]        pop_req;
    logic [2:0]        nop_req;
    push_req = $urandom_range(0, 1) ? rdq_pkg::REQ_PUSH_FRONT : rdq_pkg::REQ_PUSH_BACK;
    pop_req  = $urandom_range(0, 1) ? rdq_pkg::REQ_POP_FRONT : rdq_pkg::REQ_POP_BACK;
    nop_req  = $urandom_range(0, 1) ? REQ_NOP_6 : REQ_NOP_7;
    r = $urandom_range(0, 99);
    if (mode == MODE_FILL) begin
      w.req_type = (r < 92) ? push_req : (r < 96) ? rdq_pkg::REQ_COUNT :
                   (r < 98) ? pop_req : rdq_pkg::REQ_DELETE;
    end else if (mode == MODE_DRAIN) begin
      w.req_type = (r < 72) ? pop_req : (r < 84) ? push_req :
                   (r < 92) ? rdq_pkg::REQ_COUNT : (r < 97) ? rdq_pkg::REQ_DELETE : nop_req;
    end else begin
      w.req_type = (r < 40) ? push_req : (r < 70) ? pop_req :
                   (r < 82) ? rdq_pkg::REQ_COUNT : (r < 94) ? rdq_pkg::REQ_DELETE : nop_req;
    end
    w.entry_year      = rdq_pkg::YEAR_W'(pick_year());
    w.entry_flag      = 1'($urandom_range(0, 1));
    w.entry_title_ref = rdq_pkg::TITLE_W'($urandom_range(0, 65535));
    w.match_kind      = ($urandom_range(0, 15) == 0) ? MATCH_UNUSED :
                        2'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0:       w.year_limit = '0;
      1:       w.year_limit = '1;
      2:       w.year_limit = rdq_pkg::YEAR_W'(YEAR_OLD);
      3:       w.year_limit = rdq_pkg::YEAR_W'(YEAR_NEW);
      default: w.year_limit = rdq_pkg::YEAR_W'($urandom_range(0, 4095));
    endcase
    return w;
  endfunction

  // Offer one word, with an optional idle burst ahead of it
  task automatic offer(input rdq_pkg::in_word_t w);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Track accepted requests and check returned words
  always @(posedge clk) begin : scoreboard
    rdq_pkg::out_word_t want;
    dir_row_t           row;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_mismatch("unexpected word", 64'(out_data), 64'(0));
        end else begin
          want = due_results.pop_front();
          if (out_data.out_year !== want.out_year)
            note_mismatch("out_year", 64'(out_data.out_year), 64'(want.out_year));
          if (out_data.out_flag !== want.out_flag)
            note_mismatch("out_flag", 64'(out_data.out_flag), 64'(want.out_flag));
          if (out_data.out_title_ref !== want.out_title_ref)
            note_mismatch("out_title_ref", 64'(out_data.out_title_ref),
                          64'(want.out_title_ref));
          if (out_data.match_count !== want.match_count)
            note_mismatch("match_count", 64'(out_data.match_count),
                          64'(want.match_count));
          if (out_data.list_size !== want.list_size)
            note_mismatch("list_size", 64'(out_data.list_size), 64'(want.list_size));
          if (out_data.status !== want.status)
            note_mismatch("status", 64'(out_data.status), 64'(want.status));
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(in_data);
        if (typed_results.size() != 0) begin
          row = typed_results.pop_front();
          if (row.fixed) want = row.want;
        end
        due_results.push_back(want);
      end
    end
  end

  // Result side: ready, random idle bursts, and one long hold-off
  initial begin : rx_side
    int n;
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #14400000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int seg;
    int k;
    int mode;
    int n;
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    rx_hold_req = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: pops report empty, count and delete find nothing
    add_row(req_word(rdq_pkg::REQ_POP_FRONT, 4095, 1, 16'hffff, rdq_pkg::MATCH_FLAG_SET,
                     4095), 1,
            res_word(0, 0, 0, 0, 0, rdq_pkg::STAT_EMPTY));
    add_row(req_word(rdq_pkg::REQ_POP_BACK, 0, 0, 0, MATCH_UNUSED, 0), 1,
            res_word(0, 0, 0, 0, 0, rdq_pkg::STAT_EMPTY));
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_FLAG_SET, 0), 1,
            res_word(0, 0, 0, 0, 0, rdq_pkg::STAT_OK));
    add_row(req_word(rdq_pkg::REQ_DELETE, 0, 0, 0, rdq_pkg::MATCH_FLAG_CLR, 0), 1,
            res_word(0, 0, 0, 0, 0, rdq_pkg::STAT_OK));
    add_row(req_word(REQ_NOP_6, 4095, 1, 16'hffff, MATCH_UNUSED, 4095), 1,
            res_word(0, 0, 0, 0, 0, rdq_pkg::STAT_OK));
    // Fill with extreme and typical records at both ends
    add_row(req_word(rdq_pkg::REQ_PUSH_BACK, 4095, 1, 16'hffff, MATCH_UNUSED, 4095), 1,
            res_word(0, 0, 0, 0, 1, rdq_pkg::STAT_OK));
    add_row(req_word(rdq_pkg::REQ_PUSH_FRONT, 0, 0, 0, rdq_pkg::MATCH_FLAG_SET, 0), 1,
            res_word(0, 0, 0, 0, 2, rdq_pkg::STAT_OK));
    add_row(req_word(rdq_pkg::REQ_PUSH_BACK, YEAR_NEW, 1, 16'h1234,
                     rdq_pkg::MATCH_FLAG_SET, 0), 1,
            res_word(0, 0, 0, 0, 3, rdq_pkg::STAT_OK));
    add_row(req_word(rdq_pkg::REQ_PUSH_FRONT, YEAR_OLD, 0, 16'ha5a5,
                     rdq_pkg::MATCH_FLAG_SET, 0), 1,
            res_word(0, 0, 0, 0, 4, rdq_pkg::STAT_OK));
    // Count under every predicate and the threshold extremes
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_FLAG_SET, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_FLAG_CLR, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_YEAR_ABOVE, YEAR_OLD),
            0, '0);
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_YEAR_ABOVE, 4095), 0, '0);
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_YEAR_ABOVE, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_COUNT, 4095, 1, 16'hffff, MATCH_UNUSED, 0), 1,
            res_word(0, 0, 0, 0, 4, rdq_pkg::STAT_OK));
    add_row(req_word(REQ_NOP_7, 4095, 1, 16'hffff, rdq_pkg::MATCH_FLAG_SET, 4095), 1,
            res_word(0, 0, 0, 0, 4, rdq_pkg::STAT_OK));
    // Pop from both ends, push one back, then delete under every predicate
    add_row(req_word(rdq_pkg::REQ_POP_FRONT, 0, 0, 0, rdq_pkg::MATCH_FLAG_SET, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_POP_BACK, 0, 0, 0, rdq_pkg::MATCH_FLAG_SET, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_PUSH_BACK, YEAR_NEW, 0, 16'h0f0f,
                     rdq_pkg::MATCH_FLAG_SET, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_DELETE, 0, 0, 0, MATCH_UNUSED, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_DELETE, 0, 0, 0, rdq_pkg::MATCH_YEAR_ABOVE,
                     YEAR_NEW - 1), 0, '0);
    add_row(req_word(rdq_pkg::REQ_DELETE, 0, 0, 0, rdq_pkg::MATCH_FLAG_SET, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_DELETE, 0, 0, 0, rdq_pkg::MATCH_FLAG_CLR, 0), 0, '0);
    add_row(req_word(rdq_pkg::REQ_COUNT, 0, 0, 0, rdq_pkg::MATCH_FLAG_CLR, 0), 1,
            res_word(0, 0, 0, 0, 0, rdq_pkg::STAT_OK));

    foreach (dir_rows[i]) begin
      typed_results.push_back(dir_rows[i]);
      offer(dir_rows[i].w);
    end

    // Random part: fill first, then mixed phases; the last segments run without gaps
    for (seg = 0; seg < SEGMENTS; seg++) begin
      mode = (seg < 2) ? MODE_FILL : $urandom_range(0, 2);
      tx_gaps = (seg < SEGMENTS - CALM_SEGS) && ($urandom_range(0, 3) != 0);
      rx_gaps = (seg < SEGMENTS - CALM_SEGS) && ($urandom_range(0, 3) != 0);
      if (seg == 3) rx_hold_req = 1'b1;
      for (k = 0; k < SEG_LEN; k++) offer(rand_request(mode));
    end
    in_valid <= 1'b0;

    // Wait for outstanding results, then watch for strays
    for (n = 0; n < 100000 && due_results.size() != 0; n++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      note_mismatch("results never returned", 64'(due_results.size()), 64'(0));

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* record_deque_with_filter.f */
design/rdq_pkg.sv
design/rdq_store.sv
design/record_deque_with_filter.sv
tb/record_deque_with_filter_tb.sv
